// ===== rtl/ofr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofr_pkg: shared types and constants of the OOK frame receiver
// Word formats, queue entry, phase and result codes, register indexes.
// ----------------------------------------------------------------------------
package ofr_pkg;

    // input word: one line bit or a release command
    typedef struct packed {
        logic command;
        logic bit_value;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_value;
        logic [7:0]  byte_index;
        logic [15:0] frame_address;
        logic [7:0]  frame_length;
        logic        reject_cause;
    } out_word_t;

    // classified operation carried from front to back
    typedef enum logic [1:0] {
        OP_BIT0    = 2'd0,
        OP_BIT1    = 2'd1,
        OP_RELEASE = 2'd2
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } entry_t;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_FRAME   = 2'd1,
        PH_PENDING = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    localparam logic CAUSE_ADDRESS  = 1'b0;
    localparam logic CAUSE_CHECKSUM = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROMISCUOUS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_PREAMBLE = 2'd2;

    localparam logic [15:0] SUM_SEED           = 16'h0055;
    localparam logic [6:0]  PREAMBLE_MAX       = 7'd127;
    localparam logic [6:0]  MIN_PREAMBLE_RESET = 7'd20;
    localparam logic [8:0]  HEADER_BYTES       = 9'd3;

    // front-to-back queue
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

endpackage
`default_nettype wire

// ===== rtl/ofr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofr_front: input stage
// Registers each accepted word as a classified operation and hands it to
// the queue; stalls only while its register holds a word the queue refuses.
// ----------------------------------------------------------------------------
module ofr_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire ofr_pkg::in_word_t in_data,
    input  wire logic             q_full,
    output ofr_pkg::entry_t       push
);
    import ofr_pkg::*;

    logic valid_reg, valid_next;
    op_t  op_reg, op_next;
    logic accept, pushed;

    assign in_stall = valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign pushed   = valid_reg && !q_full;

    // classify the incoming word
    always_comb
    begin
        valid_next = valid_reg;
        op_next    = op_reg;
        if (pushed)
            valid_next = 1'b0;
        if (accept)
        begin
            valid_next = 1'b1;
            if (in_data.command)
                op_next = OP_RELEASE;
            else if (in_data.bit_value)
                op_next = OP_BIT1;
            else
                op_next = OP_BIT0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            op_reg    <= OP_BIT0;
        end
        else
        begin
            valid_reg <= valid_next;
            op_reg    <= op_next;
        end
    end

    assign push.valid = pushed;
    assign push.op    = op_reg;

endmodule
`default_nettype wire

// ===== rtl/ofr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofr_queue: short operation queue
// Four-entry FIFO between the input stage and the frame engine.
// ----------------------------------------------------------------------------
module ofr_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ofr_pkg::entry_t push,
    output logic                 full,
    output ofr_pkg::entry_t      head,
    input  wire logic            pop
);
    import ofr_pkg::*;

    op_t               mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign do_push = push.valid && !full;
    assign do_pop  = pop && (count_reg != '0);

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push.op;
    end

    assign head.valid = (count_reg != '0);
    assign head.op    = mem[rd_ptr_reg];

    // fill count stays within the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count above depth");

    // a pop always has an entry behind it
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");

    // the input stage pushes only when there is room
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !full)
        else $error("push into full queue");

endmodule
`default_nettype wire

// ===== rtl/ofr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofr_back: frame engine
// Preamble hunt, byte assembly, address and checksum checks, result
// register, and the configuration registers.
// ----------------------------------------------------------------------------
module ofr_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ofr_pkg::entry_t                   head,
    output logic                                   pop,
    input  wire logic                              cfg_write,
    input  wire logic [ofr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [ofr_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output ofr_pkg::out_word_t                     out_data
);
    import ofr_pkg::*;

    // configuration
    logic [15:0] own_addr_reg;
    logic        promisc_reg;
    logic [6:0]  min_pre_reg;

    // frame state
    phase_t      phase_reg, phase_next;
    logic [6:0]  pre_cnt_reg, pre_cnt_next;
    logic [11:0] bit_pos_reg, bit_pos_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  cl_reg, cl_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_word_reg, out_word_next;

    logic        bit_in;
    logic [8:0]  byte_no;
    logic [2:0]  bit_no;
    logic [7:0]  byte_done;
    logic [8:0]  ck_lo_no;
    logic        emit;
    out_word_t   emit_word;
    logic        do_hunt;
    logic        go_frame;

    // the engine takes one word whenever the queue has one and the result register can take a result
    assign pop       = head.valid && (!out_valid_reg || !out_stall);
    assign bit_in    = (head.op == OP_BIT1);
    assign byte_no   = bit_pos_reg[11:3];
    assign bit_no    = bit_pos_reg[2:0];
    assign byte_done = {bit_in, shift_reg[6:0]};
    assign ck_lo_no  = HEADER_BYTES + {1'b0, len_reg};

    // frame engine next state
    always_comb
    begin
        phase_next   = phase_reg;
        pre_cnt_next = pre_cnt_reg;
        bit_pos_next = bit_pos_reg;
        shift_next   = shift_reg;
        addr_next    = addr_reg;
        len_next     = len_reg;
        sum_next     = sum_reg;
        cl_next      = cl_reg;
        emit         = 1'b0;
        do_hunt      = 1'b0;
        go_frame     = 1'b0;
        emit_word.kind          = KIND_BYTE;
        emit_word.byte_value    = '0;
        emit_word.byte_index    = '0;
        emit_word.frame_address = addr_reg;
        emit_word.frame_length  = len_reg;
        emit_word.reject_cause  = CAUSE_ADDRESS;

        if (pop)
        begin
            if (head.op == OP_RELEASE)
                do_hunt = 1'b1;
            else
            begin
                unique case (phase_reg)
                    PH_PENDING:
                    begin
                        // bits ignored until release
                    end
                    PH_FRAME:
                    begin
                        bit_pos_next = bit_pos_reg + 1'b1;
                        if (bit_no == 3'd0)
                            shift_next = {7'd0, bit_in};
                        else
                            shift_next = shift_reg | (8'(bit_in) << bit_no);
                        if (bit_no == 3'd7)
                        begin
                            if (byte_no == 9'd0)
                                addr_next = {8'd0, byte_done};
                            else if (byte_no == 9'd1)
                            begin
                                addr_next = {byte_done, addr_reg[7:0]};
                                if (!promisc_reg && ({byte_done, addr_reg[7:0]} != own_addr_reg))
                                begin
                                    emit = 1'b1;
                                    emit_word.kind          = KIND_REJECT;
                                    emit_word.frame_address = {byte_done, addr_reg[7:0]};
                                    emit_word.reject_cause  = CAUSE_ADDRESS;
                                    do_hunt = 1'b1;
                                end
                            end
                            else if (byte_no == 9'd2)
                                len_next = byte_done;
                            else if (byte_no < ck_lo_no)
                            begin
                                // payload byte
                                sum_next = sum_reg + {8'd0, byte_done};
                                emit = 1'b1;
                                emit_word.kind       = KIND_BYTE;
                                emit_word.byte_value = byte_done;
                                emit_word.byte_index = 8'(byte_no - HEADER_BYTES);
                            end
                            else if (byte_no == ck_lo_no)
                                cl_next = byte_done;
                            else
                            begin
                                // checksum complete
                                emit = 1'b1;
                                if ({byte_done, cl_reg} == sum_reg)
                                begin
                                    emit_word.kind = KIND_ACCEPT;
                                    phase_next     = PH_PENDING;
                                end
                                else
                                begin
                                    emit_word.kind         = KIND_REJECT;
                                    emit_word.reject_cause = CAUSE_CHECKSUM;
                                    do_hunt = 1'b1;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        // preamble hunt
                        if (bit_in)
                        begin
                            if (pre_cnt_reg != PREAMBLE_MAX)
                                pre_cnt_next = pre_cnt_reg + 1'b1;
                        end
                        else
                        begin
                            do_hunt  = 1'b1;
                            go_frame = (pre_cnt_reg > min_pre_reg);
                        end
                    end
                endcase
            end
        end

        if (do_hunt)
        begin
            phase_next   = go_frame ? PH_FRAME : PH_HUNT;
            pre_cnt_next = '0;
            bit_pos_next = '0;
            shift_next   = '0;
            addr_next    = '0;
            len_next     = '0;
            sum_next     = SUM_SEED;
            cl_next      = '0;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (pop && emit)
        begin
            out_valid_next = 1'b1;
            out_word_next  = emit_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            pre_cnt_reg   <= '0;
            bit_pos_reg   <= '0;
            shift_reg     <= '0;
            addr_reg      <= '0;
            len_reg       <= '0;
            sum_reg       <= SUM_SEED;
            cl_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pre_cnt_reg   <= pre_cnt_next;
            bit_pos_reg   <= bit_pos_next;
            shift_reg     <= shift_next;
            addr_reg      <= addr_next;
            len_reg       <= len_next;
            sum_reg       <= sum_next;
            cl_reg        <= cl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg <= '0;
            promisc_reg  <= 1'b0;
            min_pre_reg  <= MIN_PREAMBLE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_OWN_ADDRESS:  own_addr_reg <= cfg_data[15:0];
                CFG_PROMISCUOUS:  promisc_reg  <= cfg_data[0];
                CFG_MIN_PREAMBLE: min_pre_reg  <= cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    // never overwrite a result that is still held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && emit && out_valid_reg && out_stall))
        else $error("result register overwritten");

    // an accepted frame leaves the engine pending
    a_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && emit && emit_word.kind == KIND_ACCEPT) |=> (phase_reg == PH_PENDING))
        else $error("accept without pending phase");

    // while pending, only a release moves the engine
    a_pending_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PENDING && !(pop && head.op == OP_RELEASE))
            |=> (phase_reg == PH_PENDING && $stable(bit_pos_reg)))
        else $error("pending frame disturbed");

endmodule
`default_nettype wire

// ===== rtl/ook_frame_receiver.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ook_frame_receiver: on-off-keyed frame receiver
// Hunts a ones preamble, assembles address, length, payload and checksum,
// streams payload bytes and ends each frame with an accept or reject word.
//
//   channel   signals                          direction   word
//   input     in_valid / in_stall / in_data    in          in_word_t
//   output    out_valid / out_stall / out_data out         out_word_t
//   config    cfg_write / cfg_index / cfg_data in          16-bit data
//
// One word per cycle sustained while out_stall is low; the frame engine updates
// its state once per word. An accepted word goes from the input register into
// the queue, then from the queue through the engine into the result register.
// The four-entry queue absorbs output stalls before the input side stalls.
// Reset clears all control state and loads the configuration defaults; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module ook_frame_receiver (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire ofr_pkg::in_word_t               in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output ofr_pkg::out_word_t                   out_data,
    input  wire logic                            cfg_write,
    input  wire logic [ofr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ofr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ofr_pkg::*;

    entry_t push;
    entry_t head;
    logic   q_full;
    logic   pop;

    // input stage
    ofr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (push)
    );

    // decoupling queue
    ofr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    // frame engine
    ofr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire
